[hw/rtl/chgs_pkg.sv]
package chgs_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 16;

    // Controller states
    typedef enum logic [5:0] {
        ST_LOAD,
        ST_SW0,
        ST_SW1,
        ST_SW2,
        ST_SRT_RDK,
        ST_SRT_KEY,
        ST_SRT_RDP,
        ST_SRT_LDR,
        ST_SRT_MUL,
        ST_SRT_DEC,
        ST_SRT_PUT,
        ST_PR_START,
        ST_PR_LDQ,
        ST_PR_CHK,
        ST_PR_LDR,
        ST_PR_MUL,
        ST_PR_DEC,
        ST_PR_END,
        ST_SC_INIT0,
        ST_SC_INIT1,
        ST_SC_INIT2,
        ST_SC_LOOP,
        ST_SC_LDR,
        ST_SC_MUL,
        ST_SC_DEC,
        ST_SC_RDP,
        ST_SC_LDP,
        ST_SC_PUSH,
        ST_OUT_RS,
        ST_OUT_RM,
        ST_OUT_LD,
        ST_DEG
    } t_state;

    // Point memory write data select
    typedef enum logic [2:0] {
        WS_IN,
        WS_RDATA,
        WS_Q,
        WS_R,
        WS_ANC
    } t_wsel;

    // Operand P load select
    typedef enum logic [1:0] {
        PS_HOLD,
        PS_ANC,
        PS_RDATA,
        PS_Q
    } t_psel;

    // Operand Q load select
    typedef enum logic [1:0] {
        QS_HOLD,
        QS_RDATA,
        QS_R,
        QS_P
    } t_qsel;

    typedef struct packed {
        logic  mem_rd;
        logic  mem_rd_stk;
        logic  mem_we;
        t_wsel wsel;
        logic  stk_we;
        logic  stk_rd;
        logic  ld_anc;
        t_psel psel;
        t_qsel qsel;
        logic  ld_r;
        logic  out_load;
        logic  out_last;
        logic  out_deg;
    } t_dp_cmd;

    typedef struct packed {
        logic in_lower;
        logic goes_first;
        logic cross_zero;
        logic cross_ge;
        logic out_free;
    } t_dp_sts;

endpackage

[hw/rtl/convex_hull_graham_scan_top.sv]
// Channel  Handshake                   Payload
// input    i_in_valid / o_in_ready     i_point_x, i_point_y, i_last_point
// output   o_out_valid / i_out_ready   o_hull_x, o_hull_y, o_hull_last, o_degenerate
//
// A point without the last flag is stored. The last point starts the hull run: an
// insertion sort by angle, each compare being one point-memory read and one product stage,
// then pruning of the candidates, the stack scan with its pushes and pops, and the
// emission of each vertex, all bound by the one comparator.
// Reset is synchronous, active low; it empties the point set and the output register.
// Output stalls hold the controller at the next vertex; input is refused during a run.
module convex_hull_graham_scan_top #(
    parameter int MAX_POINTS  = chgs_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = chgs_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic                          i_last_point,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_hull_x,
    output logic signed [COORD_WIDTH-1:0] o_hull_y,
    output logic                          o_hull_last,
    output logic                          o_degenerate
);

    localparam int AW = $clog2(MAX_POINTS);

    chgs_pkg::t_dp_cmd w_cmd;
    chgs_pkg::t_dp_sts w_sts;
    logic [AW-1:0]     w_mem_raddr, w_mem_waddr, w_stk_raddr, w_stk_waddr, w_stk_wdata;

    // Sequencer
    chgs_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_point (i_last_point),
        .o_in_ready   (o_in_ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_mem_raddr  (w_mem_raddr),
        .o_mem_waddr  (w_mem_waddr),
        .o_stk_raddr  (w_stk_raddr),
        .o_stk_waddr  (w_stk_waddr),
        .o_stk_wdata  (w_stk_wdata)
    );

    // Memories, geometry and output register
    chgs_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_cmd        (w_cmd),
        .i_mem_raddr  (w_mem_raddr),
        .i_mem_waddr  (w_mem_waddr),
        .i_stk_raddr  (w_stk_raddr),
        .i_stk_waddr  (w_stk_waddr),
        .i_stk_wdata  (w_stk_wdata),
        .o_sts        (w_sts),
        .o_hull_x     (o_hull_x),
        .o_hull_y     (o_hull_y),
        .o_hull_last  (o_hull_last),
        .o_degenerate (o_degenerate),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready)
    );

endmodule

[hw/rtl/chgs_dp.sv]
module chgs_dp #(
    parameter int MAX_POINTS  = chgs_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = chgs_pkg::COORD_WIDTH_DEF,
    localparam int AW = $clog2(MAX_POINTS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  chgs_pkg::t_dp_cmd             i_cmd,
    input  logic [AW-1:0]                 i_mem_raddr,
    input  logic [AW-1:0]                 i_mem_waddr,
    input  logic [AW-1:0]                 i_stk_raddr,
    input  logic [AW-1:0]                 i_stk_waddr,
    input  logic [AW-1:0]                 i_stk_wdata,
    output chgs_pkg::t_dp_sts             o_sts,
    output logic signed [COORD_WIDTH-1:0] o_hull_x,
    output logic signed [COORD_WIDTH-1:0] o_hull_y,
    output logic                          o_hull_last,
    output logic                          o_degenerate,
    output logic                          o_out_valid,
    input  logic                          i_out_ready
);

    localparam int CW = COORD_WIDTH;
    localparam int PTW = 2 * CW;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    // Points are packed as {y, x}
    logic [PTW-1:0] r_mem [MAX_POINTS];
    logic [AW-1:0]  r_stk [MAX_POINTS];
    logic [PTW-1:0] r_rdata;
    logic [AW-1:0]  r_stk_rdata;
    logic [PTW-1:0] r_anc, r_p, r_q, r_r;
    logic [PTW-1:0] n_wdata;
    logic [AW-1:0]  w_raddr;

    logic signed [PW-1:0] r_m1, r_m2, r_m3, r_m4, r_m5, r_m6;
    logic signed [DW-1:0] w_px, w_py, w_qx, w_qy, w_rx, w_ry;
    logic signed [DW-1:0] w_dqpy, w_drqx, w_dqpx, w_drqy, w_drpx, w_drpy;
    logic signed [PW:0]   w_cross, w_dq, w_dr;
    logic                 w_da, w_db;

    logic                 r_out_valid;
    logic signed [CW-1:0] r_hx, r_hy;
    logic                 r_hlast, r_hdeg;

    // Select write data and read address
    always_comb begin
        unique case (i_cmd.wsel)
            chgs_pkg::WS_IN:    n_wdata = {i_point_y, i_point_x};
            chgs_pkg::WS_RDATA: n_wdata = r_rdata;
            chgs_pkg::WS_Q:     n_wdata = r_q;
            chgs_pkg::WS_R:     n_wdata = r_r;
            chgs_pkg::WS_ANC:   n_wdata = r_anc;
            default:            n_wdata = r_rdata;
        endcase
    end

    assign w_raddr = i_cmd.mem_rd_stk ? r_stk_rdata : i_mem_raddr;

    // Point memory and hull stack memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_mem_waddr] <= n_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[w_raddr];
        end
        if (i_cmd.stk_we) begin
            r_stk[i_stk_waddr] <= i_stk_wdata;
        end
        if (i_cmd.stk_rd) begin
            r_stk_rdata <= r_stk[i_stk_raddr];
        end
    end

    // Operand registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_anc) begin
            r_anc <= {i_point_y, i_point_x};
        end
        unique case (i_cmd.psel)
            chgs_pkg::PS_ANC:   r_p <= r_anc;
            chgs_pkg::PS_RDATA: r_p <= r_rdata;
            chgs_pkg::PS_Q:     r_p <= r_q;
            default:            r_p <= r_p;
        endcase
        unique case (i_cmd.qsel)
            chgs_pkg::QS_RDATA: r_q <= r_rdata;
            chgs_pkg::QS_R:     r_q <= r_r;
            chgs_pkg::QS_P:     r_q <= r_p;
            default:            r_q <= r_q;
        endcase
        if (i_cmd.ld_r) begin
            r_r <= r_rdata;
        end
    end

    // Widen coordinates and form differences
    assign w_px = $signed({r_p[CW-1], r_p[CW-1:0]});
    assign w_py = $signed({r_p[PTW-1], r_p[PTW-1:CW]});
    assign w_qx = $signed({r_q[CW-1], r_q[CW-1:0]});
    assign w_qy = $signed({r_q[PTW-1], r_q[PTW-1:CW]});
    assign w_rx = $signed({r_r[CW-1], r_r[CW-1:0]});
    assign w_ry = $signed({r_r[PTW-1], r_r[PTW-1:CW]});

    assign w_dqpy = w_qy - w_py;
    assign w_drqx = w_rx - w_qx;
    assign w_dqpx = w_qx - w_px;
    assign w_drqy = w_ry - w_qy;
    assign w_drpx = w_rx - w_px;
    assign w_drpy = w_ry - w_py;

    // Register products for the turn test and the distance compare
    always_ff @(posedge i_clk) begin
        r_m1 <= w_dqpy * w_drqx;
        r_m2 <= w_dqpx * w_drqy;
        r_m3 <= w_dqpx * w_dqpx;
        r_m4 <= w_dqpy * w_dqpy;
        r_m5 <= w_drpx * w_drpx;
        r_m6 <= w_drpy * w_drpy;
    end

    assign w_cross = $signed({r_m1[PW-1], r_m1}) - $signed({r_m2[PW-1], r_m2});
    assign w_dq    = $signed({r_m3[PW-1], r_m3}) + $signed({r_m4[PW-1], r_m4});
    assign w_dr    = $signed({r_m5[PW-1], r_m5}) + $signed({r_m6[PW-1], r_m6});
    assign w_da    = (r_q == r_p);
    assign w_db    = (r_r == r_p);

    // Status to the controller
    always_comb begin
        o_sts.in_lower = (i_point_y < $signed(r_anc[PTW-1:CW])) ||
                         ((i_point_y == $signed(r_anc[PTW-1:CW])) &&
                          (i_point_x < $signed(r_anc[CW-1:0])));
        o_sts.cross_zero = (w_cross == '0);
        o_sts.cross_ge   = !w_cross[PW];
        if (w_da || w_db) begin
            o_sts.goes_first = w_da && !w_db;
        end else if (w_cross != '0) begin
            o_sts.goes_first = w_cross[PW];
        end else begin
            o_sts.goes_first = (w_dq < w_dr);
        end
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_hx    <= i_cmd.out_deg ? '0 : $signed(r_rdata[CW-1:0]);
            r_hy    <= i_cmd.out_deg ? '0 : $signed(r_rdata[PTW-1:CW]);
            r_hlast <= i_cmd.out_last;
            r_hdeg  <= i_cmd.out_deg;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hull_x     = r_hx;
    assign o_hull_y     = r_hy;
    assign o_hull_last  = r_hlast;
    assign o_degenerate = r_hdeg;

endmodule

[hw/rtl/chgs_ctrl.sv]
module chgs_ctrl #(
    parameter int MAX_POINTS = chgs_pkg::MAX_POINTS_DEF,
    localparam int AW = $clog2(MAX_POINTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last_point,
    output logic              o_in_ready,
    input  chgs_pkg::t_dp_sts i_sts,
    output chgs_pkg::t_dp_cmd o_cmd,
    output logic [AW-1:0]     o_mem_raddr,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [AW-1:0]     o_stk_raddr,
    output logic [AW-1:0]     o_stk_waddr,
    output logic [AW-1:0]     o_stk_wdata
);

    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam logic [CNTW-1:0] MAXN = CNTW'(MAX_POINTS);
    localparam logic [CNTW-1:0] ONE = CNTW'(1);
    localparam logic [CNTW-1:0] TWO = CNTW'(2);
    localparam logic [CNTW-1:0] THREE = CNTW'(3);

    chgs_pkg::t_state r_state, n_state;
    logic [CNTW-1:0]  r_n, n_n, r_i, n_i, r_j, n_j, r_m, n_m, r_d, n_d;
    logic [AW-1:0]    r_aidx, n_aidx;
    logic [CNTW-1:0]  w_ip1, w_jm1, w_dm1, w_dm3;

    assign w_ip1 = r_i + ONE;
    assign w_jm1 = r_j - ONE;
    assign w_dm1 = r_d - ONE;
    assign w_dm3 = r_d - THREE;

    // State and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chgs_pkg::ST_LOAD;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_m     <= '0;
            r_d     <= '0;
            r_aidx  <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_m     <= n_m;
            r_d     <= n_d;
            r_aidx  <= n_aidx;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_m         = r_m;
        n_d         = r_d;
        n_aidx      = r_aidx;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_mem_raddr = r_i[AW-1:0];
        o_mem_waddr = r_n[AW-1:0];
        o_stk_raddr = w_dm1[AW-1:0];
        o_stk_waddr = r_d[AW-1:0];
        o_stk_wdata = r_i[AW-1:0];
        unique case (r_state)
            // Store points, track the lowest one
            chgs_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_n < MAXN) begin
                        o_cmd.mem_we = 1'b1;
                        o_cmd.wsel   = chgs_pkg::WS_IN;
                        n_n          = r_n + ONE;
                        if (r_n == '0 || i_sts.in_lower) begin
                            o_cmd.ld_anc = 1'b1;
                            n_aidx       = r_n[AW-1:0];
                        end
                    end
                    if (i_last_point) begin
                        n_state = chgs_pkg::ST_SW0;
                    end
                end
            end
            // Move the anchor to entry zero
            chgs_pkg::ST_SW0: begin
                o_cmd.mem_rd = 1'b1;
                o_mem_raddr  = '0;
                n_state      = chgs_pkg::ST_SW1;
            end
            chgs_pkg::ST_SW1: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = chgs_pkg::WS_RDATA;
                o_mem_waddr  = r_aidx;
                n_state      = chgs_pkg::ST_SW2;
            end
            chgs_pkg::ST_SW2: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = chgs_pkg::WS_ANC;
                o_mem_waddr  = '0;
                o_cmd.psel   = chgs_pkg::PS_ANC;
                if (r_n > TWO) begin
                    n_i     = TWO;
                    n_state = chgs_pkg::ST_SRT_RDK;
                end else begin
                    n_state = chgs_pkg::ST_PR_START;
                end
            end
            // Insertion sort by angle around the anchor
            chgs_pkg::ST_SRT_RDK: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = chgs_pkg::ST_SRT_KEY;
            end
            chgs_pkg::ST_SRT_KEY: begin
                o_cmd.qsel = chgs_pkg::QS_RDATA;
                n_j        = r_i;
                n_state    = chgs_pkg::ST_SRT_RDP;
            end
            chgs_pkg::ST_SRT_RDP: begin
                if (r_j > ONE) begin
                    o_cmd.mem_rd = 1'b1;
                    o_mem_raddr  = w_jm1[AW-1:0];
                    n_state      = chgs_pkg::ST_SRT_LDR;
                end else begin
                    n_state = chgs_pkg::ST_SRT_PUT;
                end
            end
            chgs_pkg::ST_SRT_LDR: begin
                o_cmd.ld_r = 1'b1;
                n_state    = chgs_pkg::ST_SRT_MUL;
            end
            chgs_pkg::ST_SRT_MUL: begin
                n_state = chgs_pkg::ST_SRT_DEC;
            end
            chgs_pkg::ST_SRT_DEC: begin
                if (i_sts.goes_first) begin
                    o_cmd.mem_we = 1'b1;
                    o_cmd.wsel   = chgs_pkg::WS_R;
                    o_mem_waddr  = r_j[AW-1:0];
                    n_j          = w_jm1;
                    n_state      = chgs_pkg::ST_SRT_RDP;
                end else begin
                    n_state = chgs_pkg::ST_SRT_PUT;
                end
            end
            chgs_pkg::ST_SRT_PUT: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = chgs_pkg::WS_Q;
                o_mem_waddr  = r_j[AW-1:0];
                n_i          = w_ip1;
                if (w_ip1 < r_n) begin
                    n_state = chgs_pkg::ST_SRT_RDK;
                end else begin
                    n_state = chgs_pkg::ST_PR_START;
                end
            end
            // Keep only the farthest point of each collinear run
            chgs_pkg::ST_PR_START: begin
                n_m = ONE;
                if (r_n < TWO) begin
                    n_state = chgs_pkg::ST_PR_END;
                end else begin
                    n_i          = ONE;
                    o_cmd.mem_rd = 1'b1;
                    o_mem_raddr  = ONE[AW-1:0];
                    n_state      = chgs_pkg::ST_PR_LDQ;
                end
            end
            chgs_pkg::ST_PR_LDQ: begin
                o_cmd.qsel = chgs_pkg::QS_RDATA;
                n_state    = chgs_pkg::ST_PR_CHK;
            end
            chgs_pkg::ST_PR_CHK: begin
                if (w_ip1 < r_n) begin
                    o_cmd.mem_rd = 1'b1;
                    o_mem_raddr  = w_ip1[AW-1:0];
                    n_state      = chgs_pkg::ST_PR_LDR;
                end else begin
                    o_cmd.mem_we = 1'b1;
                    o_cmd.wsel   = chgs_pkg::WS_Q;
                    o_mem_waddr  = r_m[AW-1:0];
                    n_m          = r_m + ONE;
                    n_state      = chgs_pkg::ST_PR_END;
                end
            end
            chgs_pkg::ST_PR_LDR: begin
                o_cmd.ld_r = 1'b1;
                n_state    = chgs_pkg::ST_PR_MUL;
            end
            chgs_pkg::ST_PR_MUL: begin
                n_state = chgs_pkg::ST_PR_DEC;
            end
            chgs_pkg::ST_PR_DEC: begin
                o_cmd.qsel = chgs_pkg::QS_R;
                n_i        = w_ip1;
                n_state    = chgs_pkg::ST_PR_CHK;
                if (!i_sts.cross_zero) begin
                    o_cmd.mem_we = 1'b1;
                    o_cmd.wsel   = chgs_pkg::WS_Q;
                    o_mem_waddr  = r_m[AW-1:0];
                    n_m          = r_m + ONE;
                end
            end
            chgs_pkg::ST_PR_END: begin
                if (r_m < THREE) begin
                    n_state = chgs_pkg::ST_DEG;
                end else begin
                    n_state = chgs_pkg::ST_SC_INIT0;
                end
            end
            // Seed the stack with the first three candidates
            chgs_pkg::ST_SC_INIT0: begin
                o_cmd.stk_we = 1'b1;
                o_stk_waddr  = '0;
                o_stk_wdata  = '0;
                o_cmd.mem_rd = 1'b1;
                o_mem_raddr  = ONE[AW-1:0];
                n_state      = chgs_pkg::ST_SC_INIT1;
            end
            chgs_pkg::ST_SC_INIT1: begin
                o_cmd.stk_we = 1'b1;
                o_stk_waddr  = ONE[AW-1:0];
                o_stk_wdata  = ONE[AW-1:0];
                o_cmd.psel   = chgs_pkg::PS_RDATA;
                o_cmd.mem_rd = 1'b1;
                o_mem_raddr  = TWO[AW-1:0];
                n_state      = chgs_pkg::ST_SC_INIT2;
            end
            chgs_pkg::ST_SC_INIT2: begin
                o_cmd.stk_we = 1'b1;
                o_stk_waddr  = TWO[AW-1:0];
                o_stk_wdata  = TWO[AW-1:0];
                o_cmd.qsel   = chgs_pkg::QS_RDATA;
                n_d          = THREE;
                n_i          = THREE;
                n_state      = chgs_pkg::ST_SC_LOOP;
            end
            // Stack scan
            chgs_pkg::ST_SC_LOOP: begin
                if (r_i < r_m) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = chgs_pkg::ST_SC_LDR;
                end else begin
                    n_state = chgs_pkg::ST_OUT_RS;
                end
            end
            chgs_pkg::ST_SC_LDR: begin
                o_cmd.ld_r = 1'b1;
                n_state    = chgs_pkg::ST_SC_MUL;
            end
            chgs_pkg::ST_SC_MUL: begin
                n_state = chgs_pkg::ST_SC_DEC;
            end
            chgs_pkg::ST_SC_DEC: begin
                if (r_d > ONE && i_sts.cross_ge) begin
                    // Pop; fetch the new second entry if there is one
                    n_d        = w_dm1;
                    o_cmd.qsel = chgs_pkg::QS_P;
                    if (r_d > TWO) begin
                        o_cmd.stk_rd = 1'b1;
                        o_stk_raddr  = w_dm3[AW-1:0];
                        n_state      = chgs_pkg::ST_SC_RDP;
                    end else begin
                        n_state = chgs_pkg::ST_SC_PUSH;
                    end
                end else begin
                    n_state = chgs_pkg::ST_SC_PUSH;
                end
            end
            chgs_pkg::ST_SC_RDP: begin
                o_cmd.mem_rd     = 1'b1;
                o_cmd.mem_rd_stk = 1'b1;
                n_state          = chgs_pkg::ST_SC_LDP;
            end
            chgs_pkg::ST_SC_LDP: begin
                o_cmd.psel = chgs_pkg::PS_RDATA;
                n_state    = chgs_pkg::ST_SC_MUL;
            end
            chgs_pkg::ST_SC_PUSH: begin
                o_cmd.stk_we = 1'b1;
                o_cmd.psel   = chgs_pkg::PS_Q;
                o_cmd.qsel   = chgs_pkg::QS_R;
                n_d          = r_d + ONE;
                n_i          = w_ip1;
                n_state      = chgs_pkg::ST_SC_LOOP;
            end
            // Pop the stack out, top first
            chgs_pkg::ST_OUT_RS: begin
                o_cmd.stk_rd = 1'b1;
                n_d          = w_dm1;
                n_state      = chgs_pkg::ST_OUT_RM;
            end
            chgs_pkg::ST_OUT_RM: begin
                o_cmd.mem_rd     = 1'b1;
                o_cmd.mem_rd_stk = 1'b1;
                n_state          = chgs_pkg::ST_OUT_LD;
            end
            chgs_pkg::ST_OUT_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (r_d == '0);
                    if (r_d == '0) begin
                        n_n     = '0;
                        n_state = chgs_pkg::ST_LOAD;
                    end else begin
                        n_state = chgs_pkg::ST_OUT_RS;
                    end
                end
            end
            chgs_pkg::ST_DEG: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.out_deg  = 1'b1;
                    n_n            = '0;
                    n_d            = '0;
                    n_state        = chgs_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = chgs_pkg::ST_LOAD;
            end
        endcase
    end

    // Point count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= MAXN)
        else $error("point count beyond store depth");

    // Stack never deeper than the candidate count during the scan
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chgs_pkg::ST_SC_LOOP || r_state == chgs_pkg::ST_SC_PUSH) |-> r_d <= r_m)
        else $error("hull stack deeper than candidates");

    // Insertion position stays at or below the key's slot
    a_sort_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chgs_pkg::ST_SRT_DEC) |-> (r_j <= r_i && r_j > ONE))
        else $error("sort position out of range");

    // A result is loaded only when the output register can take it
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a pending one");

endmodule
